>>> design/repeating_timer_with_catchup_core_assert.svh
// ----------------------------------------------------------------------------
// Repeating timer assertion macros
// Property macros shared by the timer RTL; they reduce to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef REPEATING_TIMER_WITH_CATCHUP_CORE_ASSERT_SVH
`define REPEATING_TIMER_WITH_CATCHUP_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define RTWC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("timer assertion failed");

// Next-cycle implication, checked outside reset.
`define RTWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("timer assertion failed");

`else

`define RTWC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RTWC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> design/rtwc_pkg.sv
// ----------------------------------------------------------------------------
// Repeating timer package
// Widths, operation codes, register indexes and shared types of the timer.
// ----------------------------------------------------------------------------
`default_nettype none

package rtwc_pkg;

	// Time values are whole time units.
	localparam int TIME_BITS = 32;
	// Remaining interval needs one extra bit for period plus one.
	localparam int REM_BITS = TIME_BITS + 1;
	// Loop budget width.
	localparam int LOOP_BITS = 32;
	// Fire count width and its saturation value.
	localparam int FIRE_BITS = 16;
	localparam logic [FIRE_BITS-1:0] FIRE_MAX = '1;
	// Step counter of the divider.
	localparam int STEP_BITS = $clog2(TIME_BITS);

	// Operation codes carried on the input word.
	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_ARM     = 3'd1,
		OP_PAUSE   = 3'd2,
		OP_RESUME  = 3'd3,
		OP_SKIP    = 3'd4,
		OP_STOP    = 3'd5,
		OP_RESTART = 3'd6
	} op_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_TIME_MODE     = 3'd0,
		REG_PERIOD        = 3'd1,
		REG_INITIAL_DELAY = 3'd2,
		REG_USE_INITIAL   = 3'd3,
		REG_LOOP_TOTAL    = 3'd4,
		REG_MAX_ONCE      = 3'd5,
		REG_SKIP_FIRST    = 3'd6
	} reg_idx_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_COMMIT
	} state_t;

	// Divider status seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

>>> design/rtwc_div.sv
// ----------------------------------------------------------------------------
// Repeating timer divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rtwc_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [rtwc_pkg::TIME_BITS-1:0]  dividend,
	input  wire logic [rtwc_pkg::TIME_BITS-1:0]  divisor,
	output rtwc_pkg::div_stat_t                  stat,
	output logic      [rtwc_pkg::TIME_BITS-1:0]  quotient
);
	import rtwc_pkg::*;

	logic [TIME_BITS-1:0] rem_q;
	logic [TIME_BITS-1:0] quo_q;
	logic [TIME_BITS-1:0] dsr_q;
	logic [STEP_BITS-1:0] step_q;
	logic                 busy_q;
	logic                 done_q;
	logic [TIME_BITS:0]   trial;
	logic [TIME_BITS:0]   diff;
	logic                 take;

	// Shift the next dividend bit in and try one subtraction.
	always_comb begin
		trial = {rem_q, quo_q[TIME_BITS-1]};
		diff  = trial - {1'b0, dsr_q};
		take  = !diff[TIME_BITS];
	end

	// Control of the step sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_BITS'(TIME_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
			quo_q <= {quo_q[TIME_BITS-2:0], take};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

`default_nettype wire

>>> design/repeating_timer_with_catchup_core.sv
// ----------------------------------------------------------------------------
// Repeating timer with catch-up firing
// Reloading countdown timer that reports firings per tick, with loop budget.
// ----------------------------------------------------------------------------
// Each input word is one operation (tick, arm, pause, resume, skip, stop,
// restart) and gives exactly one result word with the fire count and the
// status flags. The block handles one word at a time: most words pass
// through accept, evaluate and commit, while a time-mode tick that expires
// and needs a catch-up count also waits in a divide step, in which the
// restoring divider works out elapsed/period one quotient bit per cycle.
// A result waits in an output register, so the next word is taken while it
// is still unread. Configuration registers are read live and take effect on
// the next word; write them only while the block is idle.
`default_nettype none

`include "repeating_timer_with_catchup_core_assert.svh"

module repeating_timer_with_catchup_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] elapsed
	input  wire logic [2:0]  s_tuser,   // [2:0] operation
	// Result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // [15:0] fire_count, [16] finished,
	                                    // [17] active, [18] paused_now, rest zero
	// Configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [31:0] cfg_data
);
	import rtwc_pkg::*;

	// Configuration registers
	logic                 time_mode_q;
	logic [TIME_BITS-1:0] period_q;
	logic [TIME_BITS-1:0] init_delay_q;
	logic                 use_init_q;
	logic [LOOP_BITS-1:0] loop_total_q;
	logic                 max_once_q;
	logic                 skip_first_q;

	// Timer state
	logic [REM_BITS-1:0]  remaining_q;
	logic [LOOP_BITS-1:0] loops_q;
	logic                 paused_q;
	logic                 skip_q;
	logic                 stop_q;
	logic                 done_q;
	logic                 armed_q;

	// Latched input word
	op_t                  op_q;
	logic [TIME_BITS-1:0] elapsed_q;

	// Output register
	logic                 m_tvalid_q;
	logic [FIRE_BITS-1:0] out_fire_q;
	logic                 out_fin_q;
	logic                 out_act_q;
	logic                 out_pau_q;

	// Sequencer
	state_t               state_q;
	state_t               state_nxt;
	logic                 out_free;
	logic                 div_start;
	logic                 commit_en;

	// Divider
	div_stat_t            div_stat;
	logic [TIME_BITS-1:0] quotient;

	// Evaluation
	logic                 run_tick;
	logic                 once;
	logic                 expire;
	logic                 need_div;
	logic [REM_BITS-1:0]  elapsed_ext;
	logic [REM_BITS-1:0]  reload_val;
	logic [REM_BITS-1:0]  first_val;
	logic [REM_BITS-1:0]  count;
	logic [REM_BITS-1:0]  fires;
	logic [REM_BITS-1:0]  nxt_remaining;
	logic [LOOP_BITS-1:0] nxt_loops;
	logic                 nxt_paused;
	logic                 nxt_skip;
	logic                 nxt_stop;
	logic                 nxt_done;
	logic                 nxt_armed;
	logic [FIRE_BITS-1:0] fires_sat;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_mode_q  <= 1'b1;
			period_q     <= '0;
			init_delay_q <= '0;
			use_init_q   <= 1'b0;
			loop_total_q <= LOOP_BITS'(1);
			max_once_q   <= 1'b0;
			skip_first_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				REG_TIME_MODE:     time_mode_q  <= cfg_data[0];
				REG_PERIOD:        period_q     <= cfg_data[TIME_BITS-1:0];
				REG_INITIAL_DELAY: init_delay_q <= cfg_data[TIME_BITS-1:0];
				REG_USE_INITIAL:   use_init_q   <= cfg_data[0];
				REG_LOOP_TOTAL:    loop_total_q <= cfg_data[LOOP_BITS-1:0];
				REG_MAX_ONCE:      max_once_q   <= cfg_data[0];
				REG_SKIP_FIRST:    skip_first_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Catch-up divider, used by each expiring time-mode tick that needs a catch-up count.
	rtwc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (elapsed_q),
		.divisor  (period_q),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// Tick qualification and the expiry test.
	always_comb begin
		elapsed_ext = {1'b0, elapsed_q};
		run_tick    = (op_q == OP_TICK) && armed_q && !done_q && !stop_q &&
		              !skip_q && !paused_q;
		once        = max_once_q || (period_q == '0);
		expire      = elapsed_ext >= remaining_q;
		need_div    = run_tick && time_mode_q && expire && !once &&
		              (loops_q != LOOP_BITS'(1));
		reload_val  = time_mode_q ? {1'b0, period_q} : {1'b0, period_q} + 1'b1;
		first_val   = time_mode_q ? {1'b0, init_delay_q} : {1'b0, init_delay_q} + 1'b1;
		count       = once ? REM_BITS'(1) : {1'b0, quotient} + 1'b1;
	end

	// Next timer state and fire count of the current word.
	always_comb begin
		nxt_remaining = remaining_q;
		nxt_loops     = loops_q;
		nxt_paused    = paused_q;
		nxt_skip      = skip_q;
		nxt_stop      = stop_q;
		nxt_done      = done_q;
		nxt_armed     = armed_q;
		fires         = '0;
		case (op_q)
			OP_TICK: begin
				if (armed_q && !done_q) begin
					if (stop_q) begin
						nxt_done = 1'b1;
					end else if (skip_q) begin
						nxt_skip = 1'b0;
					end else if (!paused_q) begin
						if (time_mode_q) begin
							if (!expire) begin
								nxt_remaining = remaining_q - elapsed_ext;
							end else if (loops_q == '0) begin
								nxt_remaining = {1'b0, period_q};
								fires         = count;
							end else if (loops_q != LOOP_BITS'(1)) begin
								nxt_remaining = {1'b0, period_q};
								if ({1'b0, loops_q} > count) begin
									nxt_loops = loops_q - count[LOOP_BITS-1:0];
									fires     = count;
								end else begin
									fires    = {1'b0, loops_q};
									nxt_done = 1'b1;
								end
							end else begin
								fires    = REM_BITS'(1);
								nxt_done = 1'b1;
							end
						end else begin
							if (remaining_q > REM_BITS'(1)) begin
								nxt_remaining = remaining_q - 1'b1;
							end else begin
								fires = REM_BITS'(1);
								if (loops_q == '0) begin
									nxt_remaining = reload_val;
								end else if (loops_q != LOOP_BITS'(1)) begin
									nxt_loops     = loops_q - 1'b1;
									nxt_remaining = reload_val;
								end else begin
									nxt_remaining = '0;
									nxt_done      = 1'b1;
								end
							end
						end
					end
				end
			end
			OP_ARM: begin
				nxt_remaining = use_init_q ? first_val : reload_val;
				nxt_loops     = loop_total_q;
				nxt_skip      = skip_first_q;
				nxt_paused    = 1'b0;
				nxt_stop      = 1'b0;
				nxt_done      = 1'b0;
				nxt_armed     = 1'b1;
			end
			OP_PAUSE:  nxt_paused = 1'b1;
			OP_RESUME: nxt_paused = 1'b0;
			OP_SKIP:   nxt_skip   = 1'b1;
			OP_STOP:   nxt_stop   = 1'b1;
			OP_RESTART: begin
				if (armed_q && !done_q) begin
					nxt_remaining = reload_val;
				end
			end
			default: ;
		endcase
		fires_sat = (fires > REM_BITS'(FIRE_MAX)) ? FIRE_MAX : fires[FIRE_BITS-1:0];
	end

	// Sequencer next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid) state_nxt = ST_EVAL;
			ST_EVAL:   state_nxt = need_div ? ST_DIV : ST_COMMIT;
			ST_DIV:    if (div_stat.done) state_nxt = ST_COMMIT;
			ST_COMMIT: if (out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		out_free  = !m_tvalid_q || m_tready;
		s_tready  = (state_q == ST_IDLE);
		div_start = (state_q == ST_EVAL) && need_div;
		commit_en = (state_q == ST_COMMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Latch the accepted word.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q      <= op_t'(s_tuser);
			elapsed_q <= s_tdata[TIME_BITS-1:0];
		end
	end

	// Timer state is updated once per word, when its result is stored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			loops_q     <= '0;
			paused_q    <= 1'b0;
			skip_q      <= 1'b0;
			stop_q      <= 1'b0;
			done_q      <= 1'b0;
			armed_q     <= 1'b0;
		end else if (commit_en) begin
			remaining_q <= nxt_remaining;
			loops_q     <= nxt_loops;
			paused_q    <= nxt_paused;
			skip_q      <= nxt_skip;
			stop_q      <= nxt_stop;
			done_q      <= nxt_done;
			armed_q     <= nxt_armed;
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit_en) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_en) begin
			out_fire_q <= fires_sat;
			out_fin_q  <= nxt_done;
			out_act_q  <= nxt_armed && !nxt_done;
			out_pau_q  <= nxt_paused;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, out_pau_q, out_act_q, out_fin_q, out_fire_q};

	// The input side only opens while the divider is at rest.
	`RTWC_ASSERT_IMPL(a_ready_div_idle, clk, arst_n, s_tready, !div_stat.busy)
	// The divider only finishes while the sequencer waits for it.
	`RTWC_ASSERT_IMPL(a_div_done_state, clk, arst_n, div_stat.done, state_q == ST_DIV)
	// A stored result is presented on the next cycle.
	`RTWC_ASSERT_NEXT(a_commit_valid, clk, arst_n, commit_en, m_tvalid)
	// Only a tick can fire.
	`RTWC_ASSERT_NEXT(a_fire_tick_only, clk, arst_n, commit_en && (op_q != OP_TICK),
		out_fire_q == '0)
	// A finished timer never reports itself active.
	`RTWC_ASSERT_IMPL(a_fin_not_active, clk, arst_n, m_tvalid, !(out_fin_q && out_act_q))

endmodule

`default_nettype wire
